[rtl/core/kfsl_pkg.sv]
// Package for the keyframe segment locator: field widths, command and register codes,
// and the beat types of the request, response and internal subtract unit.
// No dependencies; the RTL files other than kfsl_ram use it by scoped names, the testbench imports it.
package kfsl_pkg;

   localparam int KEY_W             = 32;
   localparam int FRAC_W            = 16;
   localparam int IDX_W             = 5;
   localparam int SLOT_W            = 5;
   localparam int COUNT_W           = 6;
   localparam int DEF_MAX_KEYS      = 32;
   localparam int DEF_FRACTION_BITS = 16;

   localparam int CSR_ADDR_W = 4;
   localparam int CSR_DATA_W = 32;

   localparam logic [CSR_ADDR_W-1:0] CSR_KEY_COUNT   = 4'h0;
   localparam logic [CSR_ADDR_W-1:0] CSR_CYCLIC_MODE = 4'h4;
   localparam logic [CSR_ADDR_W-1:0] CSR_SINGLE_MODE = 4'h8;

   localparam logic [COUNT_W-1:0] KEY_COUNT_RESET = 6'd1;

   localparam logic CMD_KEY_WRITE = 1'b0;
   localparam logic CMD_QUERY     = 1'b1;

   typedef struct packed {
      logic                command;
      logic [SLOT_W-1:0]   key_slot;
      logic [KEY_W-1:0]    key_time;
      logic [KEY_W-1:0]    query_time;
   } req_type;

   typedef struct packed {
      logic                at_end;
      logic [IDX_W-1:0]    last_index;
      logic [IDX_W-1:0]    next_index;
      logic [FRAC_W-1:0]   fraction;
   } rsp_type;

   typedef struct packed {
      logic [COUNT_W-1:0]  key_count;
      logic                cyclic_mode;
      logic                single_index_mode;
   } mode_type;

   typedef struct packed {
      logic [KEY_W:0]      a;
      logic [KEY_W-1:0]    b;
   } alu_in_type;

   typedef struct packed {
      logic [KEY_W:0]      diff;
      logic                borrow;
   } alu_out_type;

endpackage

[rtl/core/keyframe_segment_locator.sv]
// Keyframe segment locator. A key write beat leaves the block free for the next beat.
// A query beat holds req_stall high until the output register takes its result: 32 modulo
// steps if cyclic with a nonzero last key, a search over the keys in use, then, unless the
// search ends it, key reads, differences and up to KEY_W+FRACTION_BITS divide steps, on one
// subtract unit. The response beat shows on rsp_ in the cycle after the sequencer hands it
// over. Synchronous reset sets key_count to 1, clears both modes and empties the output.
module keyframe_segment_locator #(
   parameter int MAX_KEYS      = kfsl_pkg::DEF_MAX_KEYS,
   parameter int FRACTION_BITS = kfsl_pkg::DEF_FRACTION_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_stall,
   input  kfsl_pkg::req_type               req_data,
   output logic                            rsp_valid,
   input  logic                            rsp_stall,
   output kfsl_pkg::rsp_type               rsp_data,
   input  logic                            csr_psel,
   input  logic                            csr_penable,
   input  logic                            csr_pwrite,
   input  logic [kfsl_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  logic [kfsl_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [kfsl_pkg::CSR_DATA_W-1:0] csr_prdata,
   output logic                            csr_pready
);

   localparam int IW = $clog2(MAX_KEYS);

   logic [kfsl_pkg::COUNT_W-1:0] key_count_ff, key_count_in;
   logic                         cyclic_ff, cyclic_in, single_ff, single_in;
   logic                         rsp_valid_ff, rsp_valid_in;
   kfsl_pkg::rsp_type            rsp_data_ff;

   logic                         csr_wr, req_accept, query_start, key_wr;
   logic                         out_ready, eng_busy, eng_res_valid;
   kfsl_pkg::mode_type           mode;
   kfsl_pkg::rsp_type            eng_res;
   logic [IW-1:0]                rd_addr;
   logic [kfsl_pkg::KEY_W-1:0]   rd_data;

   assign csr_pready = 1'b1;
   assign csr_wr     = csr_psel && csr_penable && csr_pwrite;

   always_comb begin
      key_count_in = key_count_ff;
      cyclic_in    = cyclic_ff;
      single_in    = single_ff;
      if (csr_wr) begin
         unique case (csr_paddr)
            kfsl_pkg::CSR_KEY_COUNT:   key_count_in = csr_pwdata[kfsl_pkg::COUNT_W-1:0];
            kfsl_pkg::CSR_CYCLIC_MODE: cyclic_in    = csr_pwdata[0];
            kfsl_pkg::CSR_SINGLE_MODE: single_in    = csr_pwdata[0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      unique case (csr_paddr)
         kfsl_pkg::CSR_KEY_COUNT:   csr_prdata = kfsl_pkg::CSR_DATA_W'(key_count_ff);
         kfsl_pkg::CSR_CYCLIC_MODE: csr_prdata = kfsl_pkg::CSR_DATA_W'(cyclic_ff);
         kfsl_pkg::CSR_SINGLE_MODE: csr_prdata = kfsl_pkg::CSR_DATA_W'(single_ff);
         default:                   csr_prdata = '0;
      endcase
   end

   assign mode.key_count         = key_count_ff;
   assign mode.cyclic_mode       = cyclic_ff;
   assign mode.single_index_mode = single_ff;

   assign req_stall   = eng_busy;
   assign req_accept  = req_valid && !req_stall;
   assign query_start = req_accept && (req_data.command == kfsl_pkg::CMD_QUERY);
   // Writes to slots past the table depth are dropped.
   assign key_wr      = req_accept && (req_data.command == kfsl_pkg::CMD_KEY_WRITE)
                        && (32'(req_data.key_slot) < MAX_KEYS);

   kfsl_ram #(
      .WIDTH (kfsl_pkg::KEY_W),
      .DEPTH (MAX_KEYS)
   ) u_key_ram (
      .clock   (clock),
      .wr_en   (key_wr),
      .wr_addr (IW'(req_data.key_slot)),
      .wr_data (req_data.key_time),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   kfsl_engine #(
      .MAX_KEYS      (MAX_KEYS),
      .FRACTION_BITS (FRACTION_BITS)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .start      (query_start),
      .mode       (mode),
      .query_time (req_data.query_time),
      .rd_addr    (rd_addr),
      .rd_data    (rd_data),
      .busy       (eng_busy),
      .res_valid  (eng_res_valid),
      .res_ready  (out_ready),
      .res        (eng_res)
   );

   // The output register frees up in the same cycle its beat is taken.
   assign out_ready    = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = (rsp_valid_ff && rsp_stall) || eng_res_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         key_count_ff <= kfsl_pkg::KEY_COUNT_RESET;
         cyclic_ff    <= 1'b0;
         single_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         key_count_ff <= key_count_in;
         cyclic_ff    <= cyclic_in;
         single_ff    <= single_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (eng_res_valid && out_ready) begin
         rsp_data_ff <= eng_res;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

[rtl/core/kfsl_ram.sv]
// Generic simple dual-port RAM: one write port, one read port with registered read data.
// Depends on nothing; used for the key time table.
module kfsl_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 32
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

[rtl/core/kfsl_alu.sv]
// Shared subtract and compare unit of the locator: a 33-bit minus 32-bit difference
// with borrow, used for the modulo, the key search, the differences and the divide.
// Depends on kfsl_pkg.
module kfsl_alu (
   input  kfsl_pkg::alu_in_type  alu_in,
   output kfsl_pkg::alu_out_type alu_out
);

   logic [kfsl_pkg::KEY_W+1:0] full;

   assign full           = {1'b0, alu_in.a} - {2'b00, alu_in.b};
   assign alu_out.diff   = full[kfsl_pkg::KEY_W:0];
   assign alu_out.borrow = full[kfsl_pkg::KEY_W+1];

endmodule

[rtl/core/kfsl_engine.sv]
// Query sequencer of the locator: modulo, linear key search, key differences and a
// restoring fraction divide, all stepped through the shared subtract unit.
// Depends on kfsl_pkg and kfsl_alu; reads the key table through an external RAM port.
module kfsl_engine #(
   parameter int MAX_KEYS      = kfsl_pkg::DEF_MAX_KEYS,
   parameter int FRACTION_BITS = kfsl_pkg::DEF_FRACTION_BITS
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  kfsl_pkg::mode_type          mode,
   input  logic [kfsl_pkg::KEY_W-1:0]  query_time,
   output logic [$clog2(MAX_KEYS)-1:0] rd_addr,
   input  logic [kfsl_pkg::KEY_W-1:0]  rd_data,
   output logic                        busy,
   output logic                        res_valid,
   input  logic                        res_ready,
   output kfsl_pkg::rsp_type           res
);

   localparam int KW        = kfsl_pkg::KEY_W;
   localparam int IW        = $clog2(MAX_KEYS);
   localparam int NW        = $clog2(MAX_KEYS + 1);
   localparam int CB        = (FRACTION_BITS < kfsl_pkg::FRAC_W) ? FRACTION_BITS
                                                                 : kfsl_pkg::FRAC_W;
   localparam int DIV_STEPS = KW + FRACTION_BITS;
   localparam int CW        = $clog2(DIV_STEPS);
   localparam logic [kfsl_pkg::FRAC_W-1:0] FracCap =
      kfsl_pkg::FRAC_W'((64'(1) << CB) - 64'(1));

   localparam logic [3:0] S_IDLE   = 4'd0;
   localparam logic [3:0] S_LAST   = 4'd1;
   localparam logic [3:0] S_MOD    = 4'd2;
   localparam logic [3:0] S_SEARCH = 4'd3;
   localparam logic [3:0] S_RDA    = 4'd4;
   localparam logic [3:0] S_RDB    = 4'd5;
   localparam logic [3:0] S_NUMA   = 4'd6;
   localparam logic [3:0] S_NUMB   = 4'd7;
   localparam logic [3:0] S_DENA   = 4'd8;
   localparam logic [3:0] S_DENB   = 4'd9;
   localparam logic [3:0] S_CHECK  = 4'd10;
   localparam logic [3:0] S_DIV    = 4'd11;
   localparam logic [3:0] S_DONE   = 4'd12;

   logic [3:0]                  state_ff, state_in;
   logic [NW-1:0]               n_ff, n_in, k_ff, k_in;
   logic                        cyc_ff, cyc_in, single_ff, single_in;
   logic [KW-1:0]               shift_ff, shift_in, adj_ff, adj_in, rem_ff, rem_in;
   logic [KW-1:0]               dmag_ff, dmag_in, nmag_ff, nmag_in;
   logic [KW-1:0]               from_ff, from_in, to_ff, to_in;
   logic [IW-1:0]               li_ff, li_in, ni_ff, ni_in, bidx_ff, bidx_in;
   logic                        nneg_ff, nneg_in, dneg_ff, dneg_in;
   logic [CB-1:0]               quo_ff, quo_in;
   logic                        ovf_ff, ovf_in, at_end_ff, at_end_in;
   logic [kfsl_pkg::FRAC_W-1:0] frac_ff, frac_in;
   logic [CW-1:0]               cnt_ff, cnt_in;

   logic [NW-1:0]               n_start, k_next;
   logic                        found;
   logic [IW-1:0]               a_idx, b_idx;
   logic [KW-1:0]               rem_step;
   logic [CB-1:0]               quo_step;
   logic                        ovf_step;
   kfsl_pkg::alu_in_type        alu_in;
   kfsl_pkg::alu_out_type       alu_out;

   kfsl_alu u_alu (
      .alu_in  (alu_in),
      .alu_out (alu_out)
   );

   // A key count of zero acts as one; counts above the table depth are clamped.
   always_comb begin
      if (mode.key_count == '0) begin
         n_start = NW'(1);
      end else if (32'(mode.key_count) > MAX_KEYS) begin
         n_start = NW'(MAX_KEYS);
      end else begin
         n_start = NW'(mode.key_count);
      end
   end

   always_comb begin
      unique case (state_ff)
         S_MOD:    alu_in = '{a: {rem_ff, shift_ff[KW-1]}, b: dmag_ff};
         S_DIV:    alu_in = '{a: {rem_ff, nmag_ff[KW-1]}, b: dmag_ff};
         S_SEARCH: alu_in = '{a: {1'b0, adj_ff}, b: rd_data};
         S_NUMA:   alu_in = '{a: {1'b0, adj_ff}, b: from_ff};
         S_NUMB:   alu_in = '{a: {1'b0, from_ff}, b: adj_ff};
         S_DENA:   alu_in = '{a: {1'b0, to_ff}, b: from_ff};
         default:  alu_in = '{a: {1'b0, from_ff}, b: to_ff};
      endcase
   end

   // One restoring step: keep the shifted remainder on borrow, else the difference.
   assign rem_step = alu_out.borrow ? alu_in.a[KW-1:0] : alu_out.diff[KW-1:0];
   assign quo_step = {quo_ff[CB-2:0], ~alu_out.borrow};
   assign ovf_step = ovf_ff | quo_ff[CB-1];

   assign found  = alu_out.borrow;
   assign k_next = k_ff + NW'(1);
   assign a_idx  = (found && (k_ff != '0)) ? IW'(k_ff - NW'(1)) : IW'(n_ff - NW'(1));
   assign b_idx  = found ? IW'(k_ff) : '0;

   always_comb begin
      state_in  = state_ff;
      n_in      = n_ff;
      k_in      = k_ff;
      cyc_in    = cyc_ff;
      single_in = single_ff;
      shift_in  = shift_ff;
      adj_in    = adj_ff;
      rem_in    = rem_ff;
      dmag_in   = dmag_ff;
      nmag_in   = nmag_ff;
      from_in   = from_ff;
      to_in     = to_ff;
      li_in     = li_ff;
      ni_in     = ni_ff;
      bidx_in   = bidx_ff;
      nneg_in   = nneg_ff;
      dneg_in   = dneg_ff;
      quo_in    = quo_ff;
      ovf_in    = ovf_ff;
      at_end_in = at_end_ff;
      frac_in   = frac_ff;
      cnt_in    = cnt_ff;
      rd_addr   = '0;
      res_valid = 1'b0;

      unique case (state_ff)
         S_IDLE: begin
            if (start) begin
               n_in      = n_start;
               cyc_in    = mode.cyclic_mode;
               single_in = mode.single_index_mode;
               shift_in  = query_time;
               adj_in    = query_time;
               at_end_in = 1'b0;
               frac_in   = '0;
               rd_addr   = IW'(n_start - NW'(1));
               state_in  = S_LAST;
            end
         end
         S_LAST: begin
            dmag_in = rd_data;
            if (cyc_ff && (rd_data != '0)) begin
               rem_in   = '0;
               cnt_in   = CW'(KW - 1);
               state_in = S_MOD;
            end else begin
               k_in     = '0;
               state_in = S_SEARCH;
            end
         end
         S_MOD: begin
            shift_in = shift_ff << 1;
            rem_in   = rem_step;
            cnt_in   = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               adj_in   = rem_step;
               k_in     = '0;
               state_in = S_SEARCH;
            end
         end
         S_SEARCH: begin
            if (found || (k_next == n_ff)) begin
               if (!found && !cyc_ff) begin
                  at_end_in = 1'b1;
                  li_in     = IW'(n_ff - NW'(1));
                  ni_in     = single_ff ? '0 : IW'(n_ff - NW'(1));
                  state_in  = S_DONE;
               end else if (found && (k_ff == '0) && single_ff) begin
                  li_in    = '0;
                  ni_in    = '0;
                  state_in = S_DONE;
               end else begin
                  li_in    = a_idx;
                  bidx_in  = b_idx;
                  ni_in    = single_ff ? '0 : b_idx;
                  rd_addr  = a_idx;
                  state_in = S_RDA;
               end
            end else begin
               k_in    = k_next;
               rd_addr = IW'(k_next);
            end
         end
         S_RDA: begin
            from_in  = rd_data;
            rd_addr  = bidx_ff;
            state_in = S_RDB;
         end
         S_RDB: begin
            to_in    = rd_data;
            state_in = S_NUMA;
         end
         S_NUMA: begin
            nneg_in  = alu_out.borrow;
            nmag_in  = alu_out.diff[KW-1:0];
            state_in = alu_out.borrow ? S_NUMB : S_DENA;
         end
         S_NUMB: begin
            nmag_in  = alu_out.diff[KW-1:0];
            state_in = S_DENA;
         end
         S_DENA: begin
            dneg_in  = alu_out.borrow;
            dmag_in  = alu_out.diff[KW-1:0];
            state_in = alu_out.borrow ? S_DENB : S_CHECK;
         end
         S_DENB: begin
            dmag_in  = alu_out.diff[KW-1:0];
            state_in = S_CHECK;
         end
         S_CHECK: begin
            // A zero span, a zero offset or opposite signs all give a zero fraction.
            if ((dmag_ff == '0) || (nmag_ff == '0) || (nneg_ff != dneg_ff)) begin
               state_in = S_DONE;
            end else begin
               rem_in   = '0;
               quo_in   = '0;
               ovf_in   = 1'b0;
               cnt_in   = CW'(DIV_STEPS - 1);
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            nmag_in = nmag_ff << 1;
            rem_in  = rem_step;
            quo_in  = quo_step;
            ovf_in  = ovf_step;
            cnt_in  = cnt_ff - CW'(1);
            if (cnt_ff == '0) begin
               frac_in  = ovf_step ? FracCap : kfsl_pkg::FRAC_W'(quo_step);
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            res_valid = 1'b1;
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_ff @(posedge clock) begin
      n_ff      <= n_in;
      k_ff      <= k_in;
      cyc_ff    <= cyc_in;
      single_ff <= single_in;
      shift_ff  <= shift_in;
      adj_ff    <= adj_in;
      rem_ff    <= rem_in;
      dmag_ff   <= dmag_in;
      nmag_ff   <= nmag_in;
      from_ff   <= from_in;
      to_ff     <= to_in;
      li_ff     <= li_in;
      ni_ff     <= ni_in;
      bidx_ff   <= bidx_in;
      nneg_ff   <= nneg_in;
      dneg_ff   <= dneg_in;
      quo_ff    <= quo_in;
      ovf_ff    <= ovf_in;
      at_end_ff <= at_end_in;
      frac_ff   <= frac_in;
      cnt_ff    <= cnt_in;
   end

   assign busy           = (state_ff != S_IDLE);
   assign res.at_end     = at_end_ff;
   assign res.last_index = kfsl_pkg::IDX_W'(li_ff);
   assign res.next_index = kfsl_pkg::IDX_W'(ni_ff);
   assign res.fraction   = frac_ff;

endmodule

[rtl/core/kfsl_checker.sv]
// Port-level checks for the keyframe segment locator, bound to the top level.
// Depends on kfsl_pkg and keyframe_segment_locator.
module kfsl_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_stall,
   input kfsl_pkg::req_type               req_data,
   input logic                            rsp_valid,
   input logic                            rsp_stall,
   input kfsl_pkg::rsp_type               rsp_data,
   input logic                            csr_pready
);

   // A stalled response beat keeps its valid and its payload.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_data))
      else $error("stalled response beat changed");

   // An accepted query is followed by a stalled input side.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == kfsl_pkg::CMD_QUERY) |=> req_stall)
      else $error("query accepted without stalling the input");

   // A key write finishes in its own cycle and leaves the block free.
   assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && (req_data.command == kfsl_pkg::CMD_KEY_WRITE)
      |=> !req_stall)
      else $error("key write left the input stalled");

   // A new response only comes out of a query that was in progress.
   assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("response beat without a query in progress");

   assert property (@(posedge clock) disable iff (reset) csr_pready)
      else $error("register port not ready");

endmodule

bind keyframe_segment_locator kfsl_checker u_kfsl_checker (.*);

[dv/tb_keyframe_segment_locator.sv]
// Self-checking testbench for keyframe_segment_locator: loads key tables, sweeps the mode
// registers and checks every query response against a local segment predictor.
// Depends on kfsl_pkg and the keyframe_segment_locator RTL only.
module tb_keyframe_segment_locator;
   import kfsl_pkg::*;

   // The watchdog limit leaves ample margin over the slowest query plus response stalls.
   localparam int WATCHDOG_LIMIT = 3000;
   localparam int SETTLE_CYCLES  = 10;
   localparam int REPORT_LINES   = 30;

   typedef enum int {SHAPE_FINE, SHAPE_WIDE, SHAPE_DUPLICATES, SHAPE_SCRAMBLED,
                     SHAPE_ZERO_LAST} table_shape_type;

   logic                  clock       = 1'b0;
   logic                  reset       = 1'b1;
   logic                  req_valid   = 1'b0;
   logic                  req_stall;
   req_type               req_data    = '0;
   logic                  rsp_valid;
   logic                  rsp_stall   = 1'b0;
   rsp_type               rsp_data;
   logic                  csr_psel    = 1'b0;
   logic                  csr_penable = 1'b0;
   logic                  csr_pwrite  = 1'b0;
   logic [CSR_ADDR_W-1:0] csr_paddr   = '0;
   logic [CSR_DATA_W-1:0] csr_pwdata  = '0;
   logic [CSR_DATA_W-1:0] csr_prdata;
   logic                  csr_pready;

   // Predictor state: mirror of the key table and the mode registers.
   logic [KEY_W-1:0]   key_times [DEF_MAX_KEYS];
   logic [COUNT_W-1:0] cfg_key_count = KEY_COUNT_RESET;
   logic               cfg_cyclic    = 1'b0;
   logic               cfg_single    = 1'b0;
   rsp_type            expected_segments [$];

   int error_count     = 0;
   int checked_count   = 0;
   int query_count     = 0;
   int key_write_count = 0;
   int settings_count  = 0;
   int idle_cycles     = 0;
   int cycle_count     = 0;
   int stall_style     = 0;
   int burst_left      = 0;
   bit req_driving     = 1'b0;

   keyframe_segment_locator dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_data    (req_data),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_data    (rsp_data),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [FRAC_W-1:0] segment_fraction(logic [KEY_W-1:0] adj,
                                                          logic [KEY_W-1:0] from,
                                                          logic [KEY_W-1:0] to);
      logic        num_neg;
      logic        den_neg;
      logic [63:0] num_mag;
      logic [63:0] den_mag;
      logic [63:0] quotient;
      num_neg = adj < from;
      den_neg = to < from;
      num_mag = num_neg ? 64'(from - adj) : 64'(adj - from);
      den_mag = den_neg ? 64'(from - to) : 64'(to - from);
      // A negative ratio clamps to zero, as does a zero span.
      if (den_mag == 0 || num_mag == 0 || num_neg != den_neg)
         return '0;
      quotient = (num_mag << DEF_FRACTION_BITS) / den_mag;
      return (quotient > 64'hFFFF) ? 16'hFFFF : quotient[FRAC_W-1:0];
   endfunction

   function automatic int effective_count(int count);
      if (count < 1)
         return 1;
      if (count > DEF_MAX_KEYS)
         return DEF_MAX_KEYS;
      return count;
   endfunction

   function automatic rsp_type locate_segment(logic [KEY_W-1:0] query);
      rsp_type          seg;
      int               n;
      int               k;
      int               follow;
      int               prior;
      logic [KEY_W-1:0] last_key;
      logic [KEY_W-1:0] adj;
      n = effective_count(int'(cfg_key_count));
      last_key = key_times[n-1];
      adj = query;
      if (cfg_cyclic && last_key != 0)
         adj = query % last_key;
      k = n;
      for (int i = n - 1; i >= 0; i--)
         if (adj < key_times[i])
            k = i;
      seg = '0;
      if (!cfg_cyclic && k == n) begin
         seg.at_end     = 1'b1;
         seg.last_index = IDX_W'(n - 1);
         seg.next_index = cfg_single ? '0 : IDX_W'(n - 1);
      end else if (cfg_single) begin
         if (k != 0) begin
            follow = (k == n) ? 0 : k;
            seg.last_index = IDX_W'(k - 1);
            seg.fraction   = segment_fraction(adj, key_times[k-1], key_times[follow]);
         end
      end else begin
         follow = (k == n) ? 0 : k;
         prior  = (k == 0) ? n - 1 : k - 1;
         seg.last_index = IDX_W'(prior);
         seg.next_index = IDX_W'(follow);
         seg.fraction   = segment_fraction(adj, key_times[prior], key_times[follow]);
      end
      return seg;
   endfunction

   function automatic logic [CSR_DATA_W-1:0] register_value(logic [CSR_ADDR_W-1:0] addr);
      case (addr)
         CSR_KEY_COUNT:   return CSR_DATA_W'(cfg_key_count);
         CSR_CYCLIC_MODE: return CSR_DATA_W'(cfg_cyclic);
         CSR_SINGLE_MODE: return CSR_DATA_W'(cfg_single);
         default:         return '0;
      endcase
   endfunction

   // ---------------------------------------------------------------- checking

   task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
      error_count++;
      if (error_count <= REPORT_LINES)
         $display("MISMATCH %s: got 0x%0h, expected 0x%0h (after %0d responses)",
                  what, got, want, checked_count);
   endtask

   task automatic check_field(string what, logic [31:0] got, logic [31:0] want);
      if (got !== want)
         report_mismatch(what, got, want);
   endtask

   always @(posedge clock) begin : check_responses
      rsp_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (expected_segments.size() == 0) begin
            report_mismatch("response beat with no query pending", 32'(rsp_data), 0);
         end else begin
            want = expected_segments.pop_front();
            checked_count++;
            check_field("at_end", 32'(rsp_data.at_end), 32'(want.at_end));
            check_field("last_index", 32'(rsp_data.last_index), 32'(want.last_index));
            check_field("next_index", 32'(rsp_data.next_index), 32'(want.next_index));
            check_field("fraction", 32'(rsp_data.fraction), 32'(want.fraction));
         end
      end
   end

   // The receiver switches among four stall styles picked at random.
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count % 256 == 0)
         stall_style <= $urandom_range(0, 3);
      case (stall_style)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 9) < 7);
         default: rsp_stall <= (cycle_count % 7) < 3;
      endcase
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall) ||
          (csr_psel && csr_penable && csr_pready)) begin
         idle_cycles <= 0;
      end else if (idle_cycles >= WATCHDOG_LIMIT) begin
         $display("Watchdog: no beat accepted for %0d cycles, %0d responses pending",
                  idle_cycles, expected_segments.size());
         $display("Test completed with failures");
         $finish;
      end else begin
         idle_cycles <= idle_cycles + 1;
      end
   end

   // ---------------------------------------------------------------- drivers

   task automatic send_beat(req_type beat);
      int gap;
      req_valid   <= 1'b1;
      req_data    <= beat;
      req_driving = 1'b1;
      do @(posedge clock); while (req_stall);
      if (beat.command == CMD_KEY_WRITE) begin
         key_times[beat.key_slot] = beat.key_time;
         key_write_count++;
      end else begin
         expected_segments.push_back(locate_segment(beat.query_time));
         query_count++;
      end
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         gap = $urandom_range(1, 10);
         req_valid   <= 1'b0;
         req_driving = 1'b0;
         repeat (gap) @(posedge clock);
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 60)
                                                  : $urandom_range(0, 6);
      end
   endtask

   task automatic send_key_write(int slot, logic [KEY_W-1:0] stamp);
      req_type beat;
      beat.command    = CMD_KEY_WRITE;
      beat.key_slot   = SLOT_W'(slot);
      beat.key_time   = stamp;
      beat.query_time = $urandom();
      send_beat(beat);
   endtask

   task automatic send_query(logic [KEY_W-1:0] query);
      req_type beat;
      beat.command    = CMD_QUERY;
      beat.key_slot   = SLOT_W'($urandom());
      beat.key_time   = $urandom();
      beat.query_time = query;
      send_beat(beat);
   endtask

   task automatic wait_for_idle();
      if (req_driving) begin
         req_valid   <= 1'b0;
         req_driving = 1'b0;
      end
      while (expected_segments.size() != 0) @(posedge clock);
      // Key writes produce no response, so give the last one time to land.
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(logic [CSR_ADDR_W-1:0] addr, logic [CSR_DATA_W-1:0] value);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b1;
      csr_paddr   <= addr;
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      case (addr)
         CSR_KEY_COUNT:   cfg_key_count = value[COUNT_W-1:0];
         CSR_CYCLIC_MODE: cfg_cyclic    = value[0];
         CSR_SINGLE_MODE: cfg_single    = value[0];
         default: ;
      endcase
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic read_register(logic [CSR_ADDR_W-1:0] addr);
      csr_psel    <= 1'b1;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      csr_paddr   <= addr;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      check_field("register readback", csr_prdata, register_value(addr));
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      @(posedge clock);
   endtask

   task automatic apply_settings(int count, bit cyclic, bit single);
      wait_for_idle();
      write_register(CSR_KEY_COUNT, count);
      write_register(CSR_CYCLIC_MODE, 32'(cyclic));
      write_register(CSR_SINGLE_MODE, 32'(single));
      read_register(CSR_KEY_COUNT);
      read_register(CSR_CYCLIC_MODE);
      read_register(CSR_SINGLE_MODE);
      settings_count++;
   endtask

   // ---------------------------------------------------------------- stimulus helpers

   task automatic load_table_shape(table_shape_type shape, int count);
      logic [KEY_W-1:0] stamp;
      stamp = (shape == SHAPE_WIDE) ? $urandom_range(0, 32'h0100_0000)
                                    : $urandom_range(0, 32'h0004_0000);
      for (int s = 0; s < count; s++) begin
         case (shape)
            SHAPE_WIDE:       stamp += $urandom_range(32'h0100_0000, 32'h0700_0000);
            SHAPE_DUPLICATES: stamp += ($urandom_range(0, 2) == 0) ? 0
                                       : $urandom_range(1, 32'h0002_0000);
            SHAPE_SCRAMBLED:  stamp = $urandom();
            default:          stamp += $urandom_range(1, 32'h0003_0000);
         endcase
         if (shape == SHAPE_ZERO_LAST && s == count - 1)
            stamp = '0;
         send_key_write(s, stamp);
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_query_time(int n);
      int               i;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      i = $urandom_range(0, n - 1);
      lo = key_times[i];
      hi = (i + 1 < n) ? key_times[i+1] : lo;
      case ($urandom_range(0, 9))
         0, 1, 2, 3: begin
            if (hi > lo)
               return lo + $urandom_range(0, hi - lo - 1);
            return lo + $urandom_range(0, 32'h0001_0000);
         end
         4:       return lo;
         5:       return $urandom_range(0, 1) ? lo + 1 : lo - 1;
         6:       return $urandom_range(0, key_times[0]);
         7:       return key_times[n-1] * $urandom_range(1, 4)
                         + $urandom_range(0, key_times[n-1]);
         default: return $urandom();
      endcase
   endfunction

   task automatic send_random_key_write();
      int               slot;
      logic [KEY_W-1:0] lo;
      logic [KEY_W-1:0] hi;
      slot = $urandom_range(0, DEF_MAX_KEYS - 1);
      lo = (slot > 0) ? key_times[slot-1] : '0;
      hi = (slot < DEF_MAX_KEYS - 1) ? key_times[slot+1] : '1;
      // Up to half the rewrites keep the table ordered, the rest may break it.
      if ($urandom_range(0, 1) && hi >= lo)
         send_key_write(slot, lo + $urandom_range(0, hi - lo));
      else
         send_key_write(slot, $urandom());
   endtask

   // ---------------------------------------------------------------- tests

   task automatic test_register_reset();
      read_register(CSR_KEY_COUNT);
      read_register(CSR_CYCLIC_MODE);
      read_register(CSR_SINGLE_MODE);
   endtask

   // Every slot is written before any query can read it.
   task automatic test_table_load();
      send_key_write(0, 32'h0000_0000);
      for (int s = 1; s < DEF_MAX_KEYS - 1; s++)
         send_key_write(s, s * 32'h0010_0000 + $urandom_range(0, 32'h000F_FFFF));
      send_key_write(DEF_MAX_KEYS - 1, 32'hFFFF_FFFF);
   endtask

   task automatic test_directed_segments();
      apply_settings(4, 1'b0, 1'b0);
      send_key_write(0, 32'h000A_0000);
      send_key_write(1, 32'h0014_0000);
      send_key_write(2, 32'h001E_0000);
      send_key_write(3, 32'h0028_0000);
      // Two-index rules: before the first key, inside, on a key, just short of, at and past the end.
      send_query(32'h0000_0000);
      send_query(32'h000F_8000);
      send_query(32'h000A_0000);
      send_query(32'h0027_FFFF);
      send_query(32'h0028_0000);
      send_query(32'hFFFF_FFFF);
      apply_settings(4, 1'b0, 1'b1);
      send_query(32'h0005_0000);
      send_query(32'h0019_0000);
      send_query(32'h0028_0000);
      apply_settings(4, 1'b1, 1'b0);
      send_query(32'h002D_0000);
      send_query(32'hFFFF_FFFF);
      send_query(32'h0014_0000);
      apply_settings(4, 1'b1, 1'b1);
      send_query(32'h005F_0000);
      send_query(32'h0003_0000);
      // A zero last key leaves the time unwrapped and the next key index wraps to zero.
      send_key_write(3, 32'h0000_0000);
      send_query(32'h0064_0000);
      apply_settings(4, 1'b1, 1'b0);
      send_query(32'h0064_0000);
      send_query(32'h000F_0000);
      // A zero count acts as one key, so the segment has no span.
      apply_settings(0, 1'b0, 1'b0);
      send_query(32'h0000_0000);
      send_query(32'h0005_0000);
      apply_settings(63, 1'b0, 1'b0);
      send_query(32'h8000_0000);
   endtask

   task automatic run_random_phase(int count, bit cyclic, bit single, table_shape_type shape,
                                   int items);
      int n;
      apply_settings(count, cyclic, single);
      n = effective_count(count);
      load_table_shape(shape, ($urandom_range(0, 3) == 0) ? DEF_MAX_KEYS : n);
      repeat (items) begin
         if ($urandom_range(0, 9) == 0)
            send_random_key_write();
         else
            send_query(pick_query_time(n));
      end
   endtask

   task automatic test_random_settings();
      int              counts [11]  = '{1, 2, 32, 32, 32, 0, 63, 33, 5, 32, 16};
      bit              cyclics [11] = '{0, 0, 0, 1, 1, 1, 0, 1, 1, 0, 1};
      bit              singles [11] = '{0, 1, 0, 0, 1, 0, 1, 1, 0, 0, 0};
      table_shape_type shapes [11]  = '{SHAPE_FINE, SHAPE_FINE, SHAPE_WIDE, SHAPE_FINE,
                                        SHAPE_DUPLICATES, SHAPE_FINE, SHAPE_SCRAMBLED,
                                        SHAPE_ZERO_LAST, SHAPE_ZERO_LAST, SHAPE_SCRAMBLED,
                                        SHAPE_SCRAMBLED};
      for (int p = 0; p < 11; p++)
         run_random_phase(counts[p], cyclics[p], singles[p], shapes[p], 55);
      repeat (4)
         run_random_phase($urandom_range(0, 63), 1'($urandom_range(0, 1)),
                          1'($urandom_range(0, 1)),
                          table_shape_type'($urandom_range(0, 4)), 55);
   endtask

   // ---------------------------------------------------------------- sequence

   initial begin
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      test_register_reset();
      test_table_load();
      test_directed_segments();
      test_random_settings();
      wait_for_idle();
      repeat (16) @(posedge clock);
      if (expected_segments.size() != 0)
         report_mismatch("queries left without a response", expected_segments.size(), 0);
      $display("Ran %0d queries and %0d key writes under %0d register settings.",
               query_count, key_write_count, settings_count);
      $display("Checked %0d responses, %0d mismatches.", checked_count, error_count);
      if (error_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
